@@ hdl/bsp_pkg.sv @@
// Shared types and constants for the Burning Ship pixel engine.
// No dependencies; imported by the interfaces, controller, datapath and top level.
package bsp_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int COORD_W    = 10;
  localparam int ORIGIN_W   = 32;
  localparam int STEP_W     = 31;
  localparam int ITER_W     = 13;
  localparam int ARGB_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int ZW = 45;
  localparam int MW = FRAC_BITS + 1;
  localparam int PW = 2 * MW;
  localparam int QW = PW - FRAC_BITS;
  localparam int IW = PW - FRAC_BITS + 1;

  localparam int T_W        = 16;
  localparam int DIV_STEPS  = 16;
  localparam int SQRT_STEPS = 32;
  localparam int CNT_W      = 5;

  localparam logic [15:0] COLOR_SCALE = 16'd65025;

  localparam logic [CFG_IDX_W-1:0] REG_REAL_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REAL_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAG_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER    = 3'd4;

  localparam logic [ORIGIN_W-1:0] RST_REAL_ORIGIN = 32'hE3333333;
  localparam logic [ORIGIN_W-1:0] RST_IMAG_ORIGIN = 32'hE0000000;
  localparam logic [STEP_W-1:0]   RST_REAL_STEP   = 31'd603980;
  localparam logic [STEP_W-1:0]   RST_IMAG_STEP   = 31'd671089;
  localparam logic [ITER_W-1:0]   RST_MAX_ITER    = 13'd100;

  typedef struct packed {
    logic capture;
    logic init;
    logic mul;
    logic upd;
    logic div_init;
    logic div_step;
    logic pow1;
    logic pow2;
    logic pow3;
    logic sqr_init;
    logic sqg_init;
    logic sq_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic at_max;
    logic escape;
  } sts_t;

endpackage

@@ hdl/bsp_pix_if.sv @@
// Request channel carrying one pixel coordinate.
// Depends on bsp_pkg for field widths.
interface bsp_pix_if;
  import bsp_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

@@ hdl/bsp_res_if.sv @@
// Result channel carrying color, iteration count and in-set flag.
// Depends on bsp_pkg for field widths.
interface bsp_res_if;
  import bsp_pkg::*;
  logic              valid;
  logic              ready;
  logic [ARGB_W-1:0] pixel_argb;
  logic [ITER_W-1:0] iteration_count;
  logic              in_set;

  modport source (output valid, output pixel_argb, output iteration_count, output in_set,
                  input ready);
  modport sink   (input valid, input pixel_argb, input iteration_count, input in_set,
                  output ready);
endinterface

@@ hdl/bsp_ctrl.sv @@
// Sequencer for the pixel engine: handshakes, iteration loop, coloring steps.
// Depends on bsp_pkg; drives bsp_dpath through cmd_t and reads sts_t.
module bsp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bsp_pkg::sts_t sts,
  output bsp_pkg::cmd_t cmd
);
  import bsp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_MUL, S_UPD, S_DIV_INIT, S_DIV, S_POW1, S_POW2, S_POW3,
    S_SQR_INIT, S_SQR, S_SQG_INIT, S_SQG, S_FIN
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (sts.at_max) begin
          state_nxt = S_FIN;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (sts.escape) begin
          state_nxt = S_DIV_INIT;
        end else begin
          cmd.upd   = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = S_POW1;
      end
      S_POW1: begin
        cmd.pow1  = 1'b1;
        state_nxt = S_POW2;
      end
      S_POW2: begin
        cmd.pow2  = 1'b1;
        state_nxt = S_POW3;
      end
      S_POW3: begin
        cmd.pow3  = 1'b1;
        state_nxt = S_SQR_INIT;
      end
      S_SQR_INIT: begin
        cmd.sqr_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_SQR;
      end
      S_SQR: begin
        cmd.sq_step = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) state_nxt = S_SQG_INIT;
      end
      S_SQG_INIT: begin
        cmd.sqg_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_SQG;
      end
      S_SQG: begin
        cmd.sq_step = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten while held");

  a_accept_init: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_INIT))
    else $error("accepted request not started");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result load without valid");

  a_upd_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> $past(cmd.mul))
    else $error("update without products");
endmodule

@@ hdl/bsp_dpath.sv @@
// Datapath: configuration registers, point mapping, iteration, divider,
// power products, shared square root and result register. Depends on bsp_pkg.
module bsp_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bsp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [bsp_pkg::COORD_W-1:0]     pixel_x,
  input  logic [bsp_pkg::COORD_W-1:0]     pixel_y,
  input  bsp_pkg::cmd_t                   cmd,
  output bsp_pkg::sts_t                   sts,
  output logic [bsp_pkg::ARGB_W-1:0]      pixel_argb,
  output logic [bsp_pkg::ITER_W-1:0]      iteration_count,
  output logic                            in_set
);
  import bsp_pkg::*;

  logic [ORIGIN_W-1:0] real_origin_r, imag_origin_r;
  logic [STEP_W-1:0]   real_step_r, imag_step_r;
  logic [ITER_W-1:0]   max_iter_r;

  logic [COORD_W-1:0]  x_r, y_r;
  logic signed [ZW-1:0] cr_r, ci_r, zr_r, zi_r;
  logic [ITER_W-1:0]   count_r;
  logic [PW-1:0]       asq_r, bsq_r, ab_r;
  logic                big_r;

  logic [ITER_W-1:0]   rem_r;
  logic [T_W-1:0]      t_r;
  logic [2*T_W-1:0]    tt_r;
  logic [3*T_W-1:0]    t3_r;
  logic [2*T_W-1:0]    kr_r;
  logic [63:0]         kg_r;
  logic [7:0]          blue_r, red_r;
  logic [63:0]         sq_v_r;
  logic [34:0]         sq_rem_r;
  logic [31:0]         sq_root_r;

  logic [ARGB_W-1:0]   argb_r;
  logic [ITER_W-1:0]   cnt_out_r;
  logic                in_set_r;

  logic [40:0]         px, py;
  logic [ZW-1:0]       a_full, b_full;
  logic [MW-1:0]       a_m, b_m;
  logic [PW:0]         sq_sum;
  logic [PW-1:0]       d_pos, d_neg;
  logic [QW:0]         q_neg;
  logic [ITER_W:0]     div_sh;
  logic [55:0]         b255;
  logic [34:0]         sq_cur, sq_trial;
  logic [7:0]          red_val;

  always_comb begin
    px       = 41'(x_r) * 41'(real_step_r);
    py       = 41'(y_r) * 41'(imag_step_r);
    a_full   = zr_r[ZW-1] ? ZW'(-zr_r) : ZW'(zr_r);
    b_full   = zi_r[ZW-1] ? ZW'(-zi_r) : ZW'(zi_r);
    a_m      = a_full[MW-1:0];
    b_m      = b_full[MW-1:0];
    sq_sum   = {1'b0, asq_r} + {1'b0, bsq_r};
    d_pos    = asq_r - bsq_r;
    d_neg    = bsq_r - asq_r;
    q_neg    = {1'b0, d_neg[PW-1:FRAC_BITS]} + (QW+1)'(d_neg[FRAC_BITS-1:0] != '0);
    div_sh   = {rem_r, 1'b0};
    b255     = {t3_r, 8'b0} - {8'b0, t3_r};
    sq_cur   = {sq_rem_r[32:0], sq_v_r[63:62]};
    sq_trial = {1'b0, sq_root_r, 2'b01};
    red_val  = (sq_root_r[31:16] != '0) ? 8'hFF : sq_root_r[15:8];
  end

  assign sts.at_max = (count_r == max_iter_r);
  assign sts.escape = big_r || sq_sum[PW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_origin_r <= RST_REAL_ORIGIN;
      imag_origin_r <= RST_IMAG_ORIGIN;
      real_step_r   <= RST_REAL_STEP;
      imag_step_r   <= RST_IMAG_STEP;
      max_iter_r    <= RST_MAX_ITER;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_REAL_ORIGIN: real_origin_r <= cfg_wdata;
        REG_IMAG_ORIGIN: imag_origin_r <= cfg_wdata;
        REG_REAL_STEP:   real_step_r   <= cfg_wdata[STEP_W-1:0];
        REG_IMAG_STEP:   imag_step_r   <= cfg_wdata[STEP_W-1:0];
        REG_MAX_ITER:    max_iter_r    <= cfg_wdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r <= pixel_x;
      y_r <= pixel_y;
    end
    if (cmd.init) begin
      cr_r    <= $signed({{(ZW-ORIGIN_W){real_origin_r[ORIGIN_W-1]}}, real_origin_r})
               + $signed({{(ZW-41){1'b0}}, px});
      ci_r    <= $signed({{(ZW-ORIGIN_W){imag_origin_r[ORIGIN_W-1]}}, imag_origin_r})
               + $signed({{(ZW-41){1'b0}}, py});
      zr_r    <= '0;
      zi_r    <= '0;
      count_r <= '0;
    end
    if (cmd.mul) begin
      big_r <= (a_full[ZW-1:MW] != '0) || (b_full[ZW-1:MW] != '0);
      asq_r <= PW'(a_m) * PW'(a_m);
      bsq_r <= PW'(b_m) * PW'(b_m);
      ab_r  <= PW'(a_m) * PW'(b_m);
    end
    if (cmd.upd) begin
      if (asq_r >= bsq_r) begin
        zr_r <= cr_r + $signed({{(ZW-QW){1'b0}}, d_pos[PW-1:FRAC_BITS]});
      end else begin
        zr_r <= cr_r - $signed({{(ZW-QW-1){1'b0}}, q_neg});
      end
      zi_r    <= ci_r + $signed({{(ZW-IW){1'b0}}, ab_r[PW-1:FRAC_BITS-1]});
      count_r <= count_r + 1'b1;
    end
    if (cmd.div_init) begin
      rem_r <= count_r;
      t_r   <= '0;
    end
    if (cmd.div_step) begin
      if (div_sh >= {1'b0, max_iter_r}) begin
        rem_r <= ITER_W'(div_sh - {1'b0, max_iter_r});
        t_r   <= {t_r[T_W-2:0], 1'b1};
      end else begin
        rem_r <= div_sh[ITER_W-1:0];
        t_r   <= {t_r[T_W-2:0], 1'b0};
      end
    end
    if (cmd.pow1) tt_r <= (2*T_W)'(t_r) * (2*T_W)'(t_r);
    if (cmd.pow2) t3_r <= (3*T_W)'(tt_r) * (3*T_W)'(t_r);
    if (cmd.pow3) begin
      kr_r   <= (2*T_W)'(t_r) * (2*T_W)'(COLOR_SCALE);
      kg_r   <= 64'(t3_r) * 64'(COLOR_SCALE);
      blue_r <= b255[55:48];
    end
    if (cmd.sqr_init) begin
      sq_v_r    <= {32'b0, kr_r};
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end
    if (cmd.sqg_init) begin
      red_r     <= red_val;
      sq_v_r    <= kg_r;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end
    if (cmd.sq_step) begin
      sq_v_r <= {sq_v_r[61:0], 2'b00};
      if (sq_cur >= sq_trial) begin
        sq_rem_r  <= sq_cur - sq_trial;
        sq_root_r <= {sq_root_r[30:0], 1'b1};
      end else begin
        sq_rem_r  <= sq_cur;
        sq_root_r <= {sq_root_r[30:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      cnt_out_r <= count_r;
      in_set_r  <= sts.at_max;
      if (sts.at_max) begin
        argb_r <= 32'hFF000000;
      end else begin
        argb_r <= {8'hFF, red_r, sq_root_r[31:24], blue_r};
      end
    end
  end

  assign pixel_argb      = argb_r;
  assign iteration_count = cnt_out_r;
  assign in_set          = in_set_r;
endmodule

@@ hdl/burning_ship_pixel_engine_core.sv @@
// Top level of the Burning Ship escape-time pixel engine.
// Depends on bsp_pkg, bsp_pix_if, bsp_res_if, bsp_ctrl and bsp_dpath.
//
// Usage: write the view registers on the cfg_ port while idle (index 0 real
// origin, 1 imaginary origin, 2 real step, 3 imaginary step, 4 iteration
// limit). Send one pixel column/row per request on in_req; each request yields
// one result on out_res with the ARGB color, iteration count and in-set flag.
// One pixel is in flight at a time. Each iteration is a multiply step followed
// by an update step; pixels that reach the limit go straight to the result,
// while escaped pixels first run coloring: a divider, then a square-root unit
// used twice. The result sits in an output register, so the next request is
// accepted as soon as the result is loaded; if out_res stalls, the engine
// finishes the next pixel and then waits for the register to free. Reset
// restores the default view and empties the engine.
module burning_ship_pixel_engine_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bsp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  bsp_pix_if.sink                         in_req,
  bsp_res_if.source                       out_res
);
  import bsp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bsp_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .pixel_x         (in_req.pixel_x),
    .pixel_y         (in_req.pixel_y),
    .cmd             (cmd),
    .sts             (sts),
    .pixel_argb      (out_res.pixel_argb),
    .iteration_count (out_res.iteration_count),
    .in_set          (out_res.in_set)
  );
endmodule
